@@ src/stq_pkg.sv @@
// Package for the sorted timer queue: sizes, request/result/entry structs,
// command/kind/status codes and the sequencer state type.
// No dependencies.
package stq_pkg;

    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS);

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_DEL   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_DEL     = 2'd1;
    localparam logic [1:0] KIND_PENDING = 2'd2;
    localparam logic [1:0] KIND_EXPIRED = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] expiry_time;
        logic [31:0] handle;
        logic [31:0] query_id;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] timer_ident;
        logic [31:0] out_handle;
        logic [1:0]  status;
        logic        is_pending;
        logic        head_changed;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [31:0] expiry;
        logic [31:0] ident;
        logic [31:0] handle;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_PUT,
        ST_EMIT
    } state_t;

endpackage

@@ src/stq_core.sv @@
// Timer list engine: entry memory plus the sequencer that walks it one entry
// per read/compare pair. Depends on stq_pkg.
module stq_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  stq_pkg::req_t req,
    output logic          ready,
    output logic          res_valid,
    input  logic          res_ready,
    output stq_pkg::res_t res
);

    stq_pkg::state_t state_reg, state_next;
    stq_pkg::req_t   req_reg, req_next;
    stq_pkg::res_t   res_reg, res_next;
    logic [stq_pkg::IDX_W-1:0]  ptr_reg, ptr_next;
    logic [stq_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]                ident_reg, ident_next;
    logic                       found_reg, found_next;
    logic                       due_reg, due_next;
    logic [stq_pkg::NRES_W-1:0] nres_reg, nres_next;

    stq_pkg::entry_t mem [stq_pkg::CAPACITY];
    stq_pkg::entry_t rd_reg;
    logic                      wr_en;
    logic [stq_pkg::IDX_W-1:0] wr_addr;
    stq_pkg::entry_t           wr_data;
    stq_pkg::entry_t           new_entry;

    // shared compare unit
    logic [31:0] cmp_ref;
    logic        cmp_le, cmp_eq, exp_ge, due_now, id_match, match, found_now;
    logic        scan_end, due_val;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[ptr_reg];
    end

    assign cmp_ref  = (req_reg.cmd == stq_pkg::CMD_ADD) ? req_reg.expiry_time : req_reg.now;
    assign cmp_le   = rd_reg.expiry <= cmp_ref;
    assign cmp_eq   = rd_reg.expiry == cmp_ref;
    assign exp_ge   = !cmp_le || cmp_eq;
    assign due_now  = cmp_le;
    assign id_match = rd_reg.ident == req_reg.query_id;
    assign match    = (req_reg.cmd == stq_pkg::CMD_TICK) ? (ptr_reg == '0 && due_now)
                                                          : id_match;
    assign found_now = found_reg || match;
    assign scan_end  = stq_pkg::CNT_W'(ptr_reg) == cnt_reg - 1'b1;
    assign due_val   = (ptr_reg == stq_pkg::IDX_W'(1)) ? due_now : due_reg;

    assign new_entry.expiry = req_reg.expiry_time;
    assign new_entry.ident  = ident_reg;
    assign new_entry.handle = req_reg.handle;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req.cmd)
                        stq_pkg::CMD_ADD:
                        begin
                            if (cnt_reg == stq_pkg::CNT_W'(stq_pkg::CAPACITY))
                                state_next = stq_pkg::ST_EMIT;
                            else if (cnt_reg == '0)
                                state_next = stq_pkg::ST_PUT;
                            else
                                state_next = stq_pkg::ST_RD;
                        end
                        stq_pkg::CMD_TICK:
                            state_next = (cnt_reg == '0) ? stq_pkg::ST_IDLE : stq_pkg::ST_RD;
                        default:
                            state_next = (cnt_reg == '0) ? stq_pkg::ST_EMIT : stq_pkg::ST_RD;
                    endcase
                end
            end
            stq_pkg::ST_RD:
                state_next = stq_pkg::ST_CMP;
            stq_pkg::ST_CMP:
            begin
                if (req_reg.cmd == stq_pkg::CMD_ADD)
                begin
                    if (!exp_ge)
                        state_next = stq_pkg::ST_EMIT;
                    else if (ptr_reg == '0)
                        state_next = stq_pkg::ST_PUT;
                    else
                        state_next = stq_pkg::ST_RD;
                end
                else if (req_reg.cmd == stq_pkg::CMD_TICK && ptr_reg == '0 && !due_now)
                    state_next = stq_pkg::ST_IDLE;
                else
                    state_next = scan_end ? stq_pkg::ST_EMIT : stq_pkg::ST_RD;
            end
            stq_pkg::ST_PUT:
                state_next = stq_pkg::ST_EMIT;
            stq_pkg::ST_EMIT:
            begin
                if (res_ready)
                begin
                    if (req_reg.cmd == stq_pkg::CMD_TICK && !res_reg.last)
                        state_next = stq_pkg::ST_RD;
                    else
                        state_next = stq_pkg::ST_IDLE;
                end
            end
            default:
                state_next = stq_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory write
    always_comb
    begin
        req_next   = req_reg;
        res_next   = res_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        ident_next = ident_reg;
        found_next = found_reg;
        due_next   = due_reg;
        nres_next  = nres_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = rd_reg;

        unique case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next      = req;
                    found_next    = 1'b0;
                    due_next      = 1'b0;
                    nres_next     = '0;
                    res_next      = '0;
                    res_next.kind = req.cmd;
                    res_next.last = 1'b1;
                    if (req.cmd == stq_pkg::CMD_ADD)
                        ptr_next = stq_pkg::IDX_W'(cnt_reg - 1'b1);
                    else
                        ptr_next = '0;
                    unique case (req.cmd)
                        stq_pkg::CMD_ADD:
                            res_next.status = stq_pkg::STATUS_FULL;
                        stq_pkg::CMD_DEL:
                            res_next.status = stq_pkg::STATUS_EMPTY;
                        stq_pkg::CMD_QUERY:
                            res_next.timer_ident = req.query_id;
                        default:
                            res_next.status = stq_pkg::STATUS_OK;
                    endcase
                end
            end
            stq_pkg::ST_CMP:
            begin
                if (req_reg.cmd == stq_pkg::CMD_ADD)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ptr_reg + 1'b1;
                    if (exp_ge)
                    begin
                        wr_data = rd_reg;
                        if (ptr_reg != '0)
                            ptr_next = ptr_reg - 1'b1;
                    end
                    else
                    begin
                        wr_data                = new_entry;
                        cnt_next               = cnt_reg + 1'b1;
                        ident_next             = ident_reg + 1'b1;
                        res_next.timer_ident   = ident_reg;
                        res_next.status        = stq_pkg::STATUS_OK;
                        res_next.head_changed  = 1'b0;
                    end
                end
                else if (!(req_reg.cmd == stq_pkg::CMD_TICK && ptr_reg == '0 && !due_now))
                begin
                    found_next = found_now;
                    ptr_next   = ptr_reg + 1'b1;
                    // close the gap left by the removed entry
                    if (found_reg && req_reg.cmd != stq_pkg::CMD_QUERY)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ptr_reg - 1'b1;
                        wr_data = rd_reg;
                    end
                    if (req_reg.cmd == stq_pkg::CMD_TICK)
                    begin
                        if (ptr_reg == '0)
                        begin
                            res_next.kind        = stq_pkg::KIND_EXPIRED;
                            res_next.timer_ident = rd_reg.ident;
                            res_next.out_handle  = rd_reg.handle;
                            res_next.status      = stq_pkg::STATUS_OK;
                        end
                        if (ptr_reg == stq_pkg::IDX_W'(1))
                            due_next = due_now;
                    end
                    if (scan_end)
                    begin
                        unique case (req_reg.cmd)
                            stq_pkg::CMD_DEL:
                            begin
                                if (found_now)
                                begin
                                    cnt_next             = cnt_reg - 1'b1;
                                    res_next.timer_ident = req_reg.query_id;
                                    res_next.status      = stq_pkg::STATUS_OK;
                                end
                                else
                                begin
                                    res_next.timer_ident = '0;
                                    res_next.status      = stq_pkg::STATUS_NOT_FOUND;
                                end
                            end
                            stq_pkg::CMD_QUERY:
                                res_next.is_pending = found_now;
                            stq_pkg::CMD_TICK:
                            begin
                                cnt_next      = cnt_reg - 1'b1;
                                res_next.last = !due_val ||
                                    nres_reg == stq_pkg::NRES_W'(stq_pkg::MAX_RESULTS - 1);
                            end
                            default:
                                res_next.status = stq_pkg::STATUS_OK;
                        endcase
                    end
                end
            end
            stq_pkg::ST_PUT:
            begin
                wr_en                 = 1'b1;
                wr_addr               = '0;
                wr_data               = new_entry;
                cnt_next              = cnt_reg + 1'b1;
                ident_next            = ident_reg + 1'b1;
                res_next.timer_ident  = ident_reg;
                res_next.status       = stq_pkg::STATUS_OK;
                res_next.head_changed = 1'b1;
            end
            stq_pkg::ST_EMIT:
            begin
                if (res_ready)
                begin
                    nres_next  = nres_reg + 1'b1;
                    ptr_next   = '0;
                    found_next = 1'b0;
                    due_next   = 1'b0;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stq_pkg::ST_IDLE;
            cnt_reg   <= '0;
            ident_reg <= '0;
            found_reg <= 1'b0;
            due_reg   <= 1'b0;
            nres_reg  <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ident_reg <= ident_next;
            found_reg <= found_next;
            due_reg   <= due_next;
            nres_reg  <= nres_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    assign ready     = state_reg == stq_pkg::ST_IDLE;
    assign res_valid = state_reg == stq_pkg::ST_EMIT;
    assign res       = res_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= stq_pkg::CNT_W'(stq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == stq_pkg::ST_CMP || state_reg == stq_pkg::ST_PUT))
        else $error("memory write outside compare/put");

    a_ident_add: assert property (@(posedge clk) disable iff (!rst_n)
        (ident_reg != ident_next) |-> (req_reg.cmd == stq_pkg::CMD_ADD &&
                                       cnt_next == cnt_reg + 1'b1))
        else $error("id consumed without a stored timer");

    a_tick_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.kind == stq_pkg::KIND_EXPIRED) |->
            (res_reg.status == stq_pkg::STATUS_OK && req_reg.cmd == stq_pkg::CMD_TICK))
        else $error("expired result outside a tick");

endmodule

@@ src/sorted_timer_queue.sv @@
// Sorted timer queue, top level: request handshake and output result register
// around the list engine. Depends on stq_pkg and stq_core.
//
// Holds up to stq_pkg::CAPACITY timers in a memory with one read and one write
// port, kept sorted by expiry (newest first among equal expiries). Each memory
// entry passes through a read state and then a compare state: add walks the
// entries above the insert point, delete and query walk the whole list, and a
// tick spends one such walk per expired timer (up to stq_pkg::MAX_RESULTS per
// tick). A new request is taken once the last result has moved into the output
// register, even if that result is still stalled there.
module sorted_timer_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  stq_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_stall,
    output stq_pkg::res_t res
);

    logic          core_ready;
    logic          core_res_valid;
    logic          core_res_ready;
    stq_pkg::res_t core_res;
    logic          out_valid_reg, out_valid_next;
    stq_pkg::res_t out_reg, out_next;

    stq_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_valid && core_ready),
        .req       (req),
        .ready     (core_ready),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res       (core_res)
    );

    assign req_stall      = !core_ready;
    assign core_res_ready = !out_valid_reg || !res_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (core_res_ready)
        begin
            out_valid_next = core_res_valid;
            if (core_res_valid)
                out_next = core_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

@@ bench/stq_checker.sv @@
// Checker for the sorted timer queue: watches both channels, keeps its own copy
// of the timer list, predicts every result and compares it field by field.
// Depends on stq_pkg for the request/result structs and the command codes.
`timescale 1ns / 1ps

module stq_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  stq_pkg::req_t req,
    input  logic          res_valid,
    input  logic          res_stall,
    input  stq_pkg::res_t res,
    output int            fail_count,
    output int            outstanding
);

    stq_pkg::entry_t pending_list [stq_pkg::CAPACITY];
    int              list_len;
    bit [31:0]       next_id;
    stq_pkg::res_t   queued_replies [$];
    stq_pkg::res_t   oldest;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < list_len; i++)
            pending_list[i] = pending_list[i + 1];
        list_len--;
    endtask

    // Applies one request to the local timer list and queues the results it causes.
    task automatic run_timer_command(input stq_pkg::req_t r);
        stq_pkg::res_t reply;
        stq_pkg::res_t held;
        bit            have_held;
        bit            found;
        int            pos;
        int            emitted;
        int            i;
        reply      = '0;
        reply.last = 1'b1;
        case (r.cmd)
            stq_pkg::CMD_ADD:
            begin
                reply.kind = stq_pkg::KIND_ADD;
                if (list_len >= stq_pkg::CAPACITY)
                    reply.status = stq_pkg::STATUS_FULL;
                else
                begin
                    // newest goes ahead of any entry with the same expiry
                    pos = 0;
                    while (pos < list_len && pending_list[pos].expiry < r.expiry_time)
                        pos++;
                    for (i = list_len; i > pos; i--)
                        pending_list[i] = pending_list[i - 1];
                    pending_list[pos]  = '{r.expiry_time, next_id, r.handle};
                    reply.timer_ident  = next_id;
                    reply.head_changed = (pos == 0);
                    next_id++;
                    list_len++;
                end
                queued_replies.push_back(reply);
            end
            stq_pkg::CMD_DEL:
            begin
                reply.kind = stq_pkg::KIND_DEL;
                if (list_len == 0)
                    reply.status = stq_pkg::STATUS_EMPTY;
                else
                begin
                    reply.status = stq_pkg::STATUS_NOT_FOUND;
                    for (i = 0; i < list_len; i++)
                    begin
                        if (pending_list[i].ident == r.query_id)
                        begin
                            drop_entry(i);
                            reply.status      = stq_pkg::STATUS_OK;
                            reply.timer_ident = r.query_id;
                            break;
                        end
                    end
                end
                queued_replies.push_back(reply);
            end
            stq_pkg::CMD_QUERY:
            begin
                found = 1'b0;
                for (i = 0; i < list_len; i++)
                    if (pending_list[i].ident == r.query_id)
                        found = 1'b1;
                reply.kind        = stq_pkg::KIND_PENDING;
                reply.timer_ident = r.query_id;
                reply.is_pending  = found;
                queued_replies.push_back(reply);
            end
            default:
            begin
                // tick: pop due timers from the head; last goes on the final one
                emitted   = 0;
                have_held = 1'b0;
                held      = '0;
                while (emitted < stq_pkg::MAX_RESULTS && list_len > 0 &&
                       pending_list[0].expiry <= r.now)
                begin
                    if (have_held)
                        queued_replies.push_back(held);
                    held             = '0;
                    held.kind        = stq_pkg::KIND_EXPIRED;
                    held.timer_ident = pending_list[0].ident;
                    held.out_handle  = pending_list[0].handle;
                    drop_entry(0);
                    emitted++;
                    have_held = 1'b1;
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    queued_replies.push_back(held);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_len = 0;
            next_id  = '0;
            queued_replies.delete();
            outstanding = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (queued_replies.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d ident %h",
                           res.kind, res.timer_ident);
                    fail_count++;
                end
                else
                begin
                    oldest = queued_replies.pop_front();
                    check_field("kind", 32'(oldest.kind), 32'(res.kind));
                    check_field("timer_ident", oldest.timer_ident, res.timer_ident);
                    check_field("out_handle", oldest.out_handle, res.out_handle);
                    check_field("status", 32'(oldest.status), 32'(res.status));
                    check_field("is_pending", 32'(oldest.is_pending), 32'(res.is_pending));
                    check_field("head_changed", 32'(oldest.head_changed),
                                32'(res.head_changed));
                    check_field("last", 32'(oldest.last), 32'(res.last));
                end
            end
            if (req_valid && !req_stall)
                run_timer_command(req);
            outstanding = queued_replies.size();
        end
    end

endmodule

@@ bench/tb.sv @@
// Testbench top for the sorted timer queue: clock, reset, request stimulus and
// random result stalls, with the verdict. Depends on stq_pkg, sorted_timer_queue
// and stq_checker.
`timescale 1ns / 1ps

module tb;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    stq_pkg::req_t req       = '0;
    logic          res_valid;
    logic          res_stall = 1'b0;
    stq_pkg::res_t res;

    int fail_count;
    int outstanding;
    int send_idle_pct = 0;
    int res_stall_pct = 0;
    int adds_sent     = 0;

    // per phase: no idling, sender idle, receiver stalling, both
    int idle_by_phase  [4] = '{0, 68, 0, 30};
    int stall_by_phase [4] = '{0, 0, 68, 30};
    int random_by_phase[4] = '{35, 33, 33, 32};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        res_stall <= ($urandom_range(0, 99) < res_stall_pct);

    sorted_timer_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    stq_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input stq_pkg::req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (item.cmd == stq_pkg::CMD_ADD)
            adds_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        stq_pkg::req_t item;
        int            roll;
        int            i;
        int            ph;
        int            waited;
        bit [31:0]     clock_base;
        clock_base = 32'd1000;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_by_phase[ph];
            res_stall_pct = stall_by_phase[ph];
            if (ph == 0)
            begin
                // fill the list with clashing expiries and both ends of the range;
                // the last add hits a full list
                for (i = 0; i < stq_pkg::CAPACITY + 1; i++)
                begin
                    item.cmd         = stq_pkg::CMD_ADD;
                    item.expiry_time = (i == 1) ? 32'd0 :
                                       (i == 3) ? 32'hFFFF_FFFF : 32'd100 + 32'(i % 5) * 10;
                    item.handle      = (i == 0) ? 32'd0 :
                                       (i == 1) ? 32'hFFFF_FFFF : $urandom();
                    item.query_id    = $urandom();
                    item.now         = $urandom();
                    send_request(item);
                end
                send_request(stq_pkg::req_t'{stq_pkg::CMD_QUERY, $urandom(), $urandom(),
                                             32'd3, $urandom()});
                send_request(stq_pkg::req_t'{stq_pkg::CMD_QUERY, $urandom(), $urandom(),
                                             32'hFFFF_FFFF, $urandom()});
                send_request(stq_pkg::req_t'{stq_pkg::CMD_DEL, $urandom(), $urandom(),
                                             32'd5, $urandom()});
                // same id again: already gone
                send_request(stq_pkg::req_t'{stq_pkg::CMD_DEL, $urandom(), $urandom(),
                                             32'd5, $urandom()});
                send_request(stq_pkg::req_t'{stq_pkg::CMD_TICK, $urandom(), $urandom(),
                                             $urandom(), 32'd0});
                send_request(stq_pkg::req_t'{stq_pkg::CMD_TICK, $urandom(), $urandom(),
                                             $urandom(), 32'd120});
                send_request(stq_pkg::req_t'{stq_pkg::CMD_TICK, $urandom(), $urandom(),
                                             $urandom(), 32'hFFFF_FFFF});
                // list is empty from here
                send_request(stq_pkg::req_t'{stq_pkg::CMD_DEL, $urandom(), $urandom(),
                                             32'd0, $urandom()});
                send_request(stq_pkg::req_t'{stq_pkg::CMD_TICK, $urandom(), $urandom(),
                                             $urandom(), 32'hFFFF_FFFF});
                send_request(stq_pkg::req_t'{stq_pkg::CMD_QUERY, $urandom(), $urandom(),
                                             32'd0, $urandom()});
            end

            for (i = 0; i < random_by_phase[ph]; i++)
            begin
                item.cmd         = 2'($urandom_range(0, 3));
                item.expiry_time = $urandom();
                item.handle      = $urandom();
                item.query_id    = $urandom();
                item.now         = $urandom();
                roll             = $urandom_range(0, 99);
                // a few fully random requests stay as they are
                if (roll >= 8 && roll < 48)
                begin
                    item.cmd         = stq_pkg::CMD_ADD;
                    item.expiry_time = clock_base + $urandom_range(0, 60);
                end
                else if (roll >= 48 && roll < 63)
                begin
                    item.cmd      = stq_pkg::CMD_DEL;
                    item.query_id = $urandom_range(0, adds_sent);
                end
                else if (roll >= 63 && roll < 78)
                begin
                    item.cmd      = stq_pkg::CMD_QUERY;
                    item.query_id = $urandom_range(0, adds_sent);
                end
                else if (roll >= 78)
                begin
                    item.cmd   = stq_pkg::CMD_TICK;
                    clock_base = clock_base + $urandom_range(0, 25);
                    item.now   = clock_base;
                end
                send_request(item);
            end
        end
        req_valid <= 1'b0;

        waited = 0;
        while (outstanding != 0 && waited < 50000)
        begin
            @(negedge clk);
            waited++;
        end
        if (outstanding != 0)
            $error("%0d expected results never arrived", outstanding);
        // catch stray results after a tick that had nothing due
        repeat (200) @(negedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sorted_timer_queue.f @@
src/stq_pkg.sv
src/stq_core.sv
src/sorted_timer_queue.sv
bench/stq_checker.sv
bench/tb.sv
